// File: sv/srpq_pkg.sv
package srpq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdW      = 8;
  localparam int unsigned PrioW    = 4;
  localparam int unsigned OccW     = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CANCEL = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

endpackage

// File: sv/srpq_if.sv
interface srpq_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [srpq_pkg::IdW-1:0]      req_id;
  logic [srpq_pkg::PrioW-1:0]    prio;

  modport source (output valid, func, req_id, prio, input ready);
  modport sink   (input valid, func, req_id, prio, output ready);
endinterface

interface srpq_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [srpq_pkg::IdW-1:0]      out_id;
  logic [srpq_pkg::PrioW-1:0]    out_prio;
  logic [srpq_pkg::OccW-1:0]     occupancy;

  modport source (output valid, status, out_id, out_prio, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_prio, occupancy, output ready);
endinterface

// File: sv/srpq_mem.sv
module srpq_mem #(
  parameter int unsigned Depth = srpq_pkg::Capacity,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  srpq_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output srpq_pkg::entry_t      rdata_o
);

  srpq_pkg::entry_t mem_q [Depth];
  srpq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/srpq_ctrl.sv
module srpq_ctrl #(
  parameter int unsigned Capacity = srpq_pkg::Capacity,
  parameter int unsigned AddrW    = $clog2(Capacity),
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srpq_req_if.sink              in_i,
  srpq_res_if.source            res_o,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output srpq_pkg::entry_t      mem_wdata_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  srpq_pkg::entry_t      mem_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    PH_INS   = 3'b001,
    PH_SCAN  = 3'b010,
    PH_SHIFT = 3'b100
  } phase_e;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  state_e                        state_q, state_d;
  phase_e                        phase_q, phase_d;
  logic [CntW-1:0]               fill_q, fill_d;
  logic [CntW-1:0]               ptr_q, ptr_d;
  logic                          is_pop_q, is_pop_d;
  srpq_pkg::entry_t              req_q, req_d;
  srpq_pkg::status_e             status_q, status_d;
  srpq_pkg::entry_t              out_q, out_d;

  logic                          in_accept;
  logic [CntW-1:0]               ptr_dec;
  logic [CntW-1:0]               ptr_inc;
  logic                          match;

  assign in_i.ready  = (state_q == S_IDLE) || ((state_q == S_DONE) && res_o.ready);
  assign in_accept   = in_i.valid && in_i.ready;
  assign ptr_dec     = ptr_q - CntW'(1);
  assign ptr_inc     = ptr_q + CntW'(1);
  assign match       = is_pop_q || (mem_rdata_i.id == req_q.id);

  assign res_o.valid     = (state_q == S_DONE);
  assign res_o.status    = status_q;
  assign res_o.out_id    = out_q.id;
  assign res_o.out_prio  = out_q.prio;
  assign res_o.occupancy = srpq_pkg::OccW'(fill_q);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    is_pop_d    = is_pop_q;
    req_d       = req_q;
    status_d    = status_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q[AddrW-1:0];
    mem_wdata_o = req_q;
    mem_raddr_o = ptr_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
      end
      S_DONE: begin
        if (res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        unique case (phase_q)
          PH_INS: begin
            mem_raddr_o = ptr_dec[AddrW-1:0];
            if (ptr_q == '0) begin
              // Everything ahead moved back; the new request becomes the head.
              mem_we_o = 1'b1;
              fill_d   = fill_q + CntW'(1);
              state_d  = S_DONE;
            end else begin
              state_d = S_EVAL;
            end
          end
          PH_SHIFT: begin
            if (ptr_q == fill_q) begin
              fill_d  = fill_q - CntW'(1);
              state_d = S_DONE;
            end else begin
              state_d = S_EVAL;
            end
          end
          default: begin
            state_d = S_EVAL;
          end
        endcase
      end
      S_EVAL: begin
        unique case (phase_q)
          PH_INS: begin
            mem_we_o = 1'b1;
            if (mem_rdata_i.prio > req_q.prio) begin
              mem_wdata_o = mem_rdata_i;
              ptr_d       = ptr_dec;
              state_d     = S_READ;
            end else begin
              fill_d  = fill_q + CntW'(1);
              state_d = S_DONE;
            end
          end
          PH_SCAN: begin
            ptr_d = ptr_inc;
            if (match) begin
              out_d   = mem_rdata_i;
              phase_d = PH_SHIFT;
              state_d = S_READ;
            end else if (ptr_inc == fill_q) begin
              status_d = srpq_pkg::ST_NOTFOUND;
              state_d  = S_DONE;
            end else begin
              state_d = S_READ;
            end
          end
          default: begin
            // Close the gap: the entry just read moves one place toward the head.
            mem_we_o    = 1'b1;
            mem_waddr_o = ptr_dec[AddrW-1:0];
            mem_wdata_o = mem_rdata_i;
            ptr_d       = ptr_inc;
            state_d     = S_READ;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (in_accept) begin
      req_d.id   = in_i.req_id;
      req_d.prio = in_i.prio;
      status_d   = srpq_pkg::ST_OK;
      out_d      = '0;
      is_pop_d   = 1'b0;
      ptr_d      = '0;
      unique case (srpq_pkg::func_e'(in_i.func))
        srpq_pkg::FUNC_INSERT: begin
          if (fill_q == CapCnt) begin
            status_d = srpq_pkg::ST_FULL;
            state_d  = S_DONE;
          end else if (fill_q == '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            mem_wdata_o = req_d;
            fill_d      = CntW'(1);
            state_d     = S_DONE;
          end else begin
            ptr_d   = fill_q;
            phase_d = PH_INS;
            state_d = S_READ;
          end
        end
        srpq_pkg::FUNC_POP: begin
          is_pop_d = 1'b1;
          if (fill_q == '0) begin
            status_d = srpq_pkg::ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            phase_d = PH_SCAN;
            state_d = S_READ;
          end
        end
        srpq_pkg::FUNC_CANCEL: begin
          if (fill_q == '0) begin
            status_d = srpq_pkg::ST_NOTFOUND;
            state_d  = S_DONE;
          end else begin
            phase_d = PH_SCAN;
            state_d = S_READ;
          end
        end
        default: begin
          state_d = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_SCAN;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    is_pop_q <= is_pop_d;
    req_q    <= req_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

endmodule

// File: sv/sorted_priority_request_queue.sv
// A request into an empty queue, a full insert, an empty pop, a cancel on an empty queue
// and code 3 answer in the cycle after acceptance. Any other insert moves entries back one
// place from the tail until its slot is found; a pop or a cancel scans from the head and
// then moves the entries behind the match forward. One memory read and one compare
// alternate under a single sequencer. A new beat is taken when the previous result is taken.
// Reset clears the fill count and control state; queue storage is not cleared.
module sorted_priority_request_queue #(
  parameter int unsigned CAPACITY = srpq_pkg::Capacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srpq_req_if.sink   in_i,
  srpq_res_if.source res_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [AddrW-1:0]     mem_raddr;
  srpq_pkg::entry_t     mem_wdata;
  srpq_pkg::entry_t     mem_rdata;

  srpq_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  srpq_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_no_accept_while_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !in_i.ready)
    else $error("input taken while a result is stalled");

  a_full_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == srpq_pkg::ST_FULL)
    |-> res_o.occupancy == srpq_pkg::OccW'(CAPACITY))
    else $error("full reported below capacity");

  a_empty_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == srpq_pkg::ST_EMPTY) |-> res_o.occupancy == '0)
    else $error("empty reported with entries queued");

  a_fail_no_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != srpq_pkg::ST_OK)
    |-> (res_o.out_id == '0) && (res_o.out_prio == '0))
    else $error("failed operation returned an entry");

endmodule
